FILE: hw/rtl/erp_pkg.sv
// Package for the echo reply tracker: item, stage and result types, codes and constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package erp_pkg;

   // Seen map geometry: default size and the width of one memory row.
   localparam int MAP_BITS_DEF = 16384;
   localparam int ROW_BITS     = 32;

   // Depth of the queue between front and back.
   localparam int Q_DEPTH = 2;

   // Configuration register indexes.
   localparam logic REG_ECHO_IDENT   = 1'b0;
   localparam logic REG_PAYLOAD_SIZE = 1'b1;

   // Register reset values.
   localparam logic [15:0] ECHO_IDENT_RST   = 16'd0;
   localparam logic [15:0] PAYLOAD_SIZE_RST = 16'd56;

   // ICMP header bytes ahead of the payload, and the smallest payload that holds a timestamp.
   localparam logic [16:0] ICMP_HDR_BYTES = 17'd8;
   localparam logic [15:0] TIMED_MIN_SIZE = 16'd8;

   // ICMP type codes.
   localparam logic [7:0] KIND_REPLY   = 8'd0;
   localparam logic [7:0] KIND_REQUEST = 8'd8;

   // Microseconds per second.
   localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;

   // Saturation limits.
   localparam logic signed [31:0] TRIP_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TRIP_MIN  = 32'sh8000_0000;
   localparam logic signed [47:0] SUM_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN   = 48'sh8000_0000_0000;
   localparam logic        [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Item opcodes on the input channel.
   localparam logic OPC_TRANSMIT = 1'b0;
   localparam logic OPC_RECEIVE  = 1'b1;

   // Reported events.
   typedef enum logic [2:0] {
      EV_IGNORED = 3'd0,
      EV_NEW     = 3'd1,
      EV_DUP     = 3'd2,
      EV_OTHER   = 3'd3,
      EV_SENT    = 3'd4
   } erp_event_type;

   // Classes the front assigns to an item.
   typedef enum logic [1:0] {
      OP_TX     = 2'd0,
      OP_IGNORE = 2'd1,
      OP_OTHER  = 2'd2,
      OP_REPLY  = 2'd3
   } erp_op_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_CLEAR  = 2'd0,
      BK_FETCH  = 2'd1,
      BK_COMMIT = 2'd2
   } erp_back_state_type;

   // Configuration seen by the front.
   typedef struct packed {
      logic [15:0] echo_ident;
      logic [15:0] payload_size;
   } erp_cfg_type;

   // Classified item held in the queue.
   typedef struct packed {
      erp_op_type         op;
      logic               timed;
      logic [15:0]        seq;
      logic [15:0]        bytes;
      logic [7:0]         kind;
      logic signed [53:0] prod;
      logic signed [20:0] udiff;
   } erp_item_type;

   // One result item.
   typedef struct packed {
      erp_event_type      event_res;
      logic [15:0]        seq_out;
      logic [15:0]        icmp_bytes;
      logic [7:0]         kind_out;
      logic signed [31:0] trip_us;
      logic [31:0]        sent_total;
      logic [31:0]        recv_total;
      logic [31:0]        dup_total;
      logic signed [31:0] trip_min;
      logic signed [31:0] trip_max;
      logic signed [47:0] trip_total;
   } erp_result_type;

endpackage

FILE: hw/rtl/echo_reply_tracker.sv
// Echo reply tracker: one result item per input item. The back takes each item in turn
// through a seen map row read with round-trip saturation, then a commit that waits while the
// result register is not yet free; it takes no new item from the queue until that commit.
// Synchronous active-high reset; afterwards the seen map is cleared one 32-bit row a cycle,
// all MAP_BITS/32 rows (512 at the default size), while req_tready stays low.
// Top level with the register block; depends on erp_pkg, erp_front, erp_queue, erp_back.
`timescale 1ns / 1ps

module echo_reply_tracker
   import erp_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Input channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: total_len[15:0], header_words[19:16], packet_ident[35:20],
   // icmp_kind[43:36], echo_seq[59:44], sent_sec[91:60], sent_usec[111:92],
   // now_sec[143:112], now_usec[163:144], zero fill[167:164]
   input  logic [167:0] req_tdata,
   // tuser: opcode[0]
   input  logic [0:0]   req_tuser,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: seq_out[15:0], icmp_bytes[31:16], kind_out[39:32], trip_us[71:40],
   // sent_total[103:72], recv_total[135:104], dup_total[167:136], trip_min[199:168],
   // trip_max[231:200], trip_total[279:232]
   output logic [279:0] rsp_tdata,
   // tuser: event_res[2:0]
   output logic [2:0]   rsp_tuser,
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [15:0]    echo_ident_ff, echo_ident_in;
   logic [15:0]    payload_size_ff, payload_size_in;
   logic           csr_write;
   erp_cfg_type    cfg;
   erp_item_type   front_item;
   erp_item_type   q_head;
   logic           q_full;
   logic           q_empty;
   logic           q_pop;
   logic           q_push;
   logic           clearing;
   erp_result_type result;

   // Register block: always ready, written on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      echo_ident_in   = echo_ident_ff;
      payload_size_in = payload_size_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ECHO_IDENT:   echo_ident_in   = csr_pwdata[15:0];
            REG_PAYLOAD_SIZE: payload_size_in = csr_pwdata[15:0];
            default:          echo_ident_in   = echo_ident_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_ECHO_IDENT:   csr_prdata = {16'd0, echo_ident_ff};
         REG_PAYLOAD_SIZE: csr_prdata = {16'd0, payload_size_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ident_ff   <= ECHO_IDENT_RST;
         payload_size_ff <= PAYLOAD_SIZE_RST;
      end else begin
         echo_ident_ff   <= echo_ident_in;
         payload_size_ff <= payload_size_in;
      end
   end

   assign cfg.echo_ident   = echo_ident_ff;
   assign cfg.payload_size = payload_size_ff;

   // An item is taken whenever the queue has room and the map is not being cleared.
   assign req_tready = !q_full && !clearing;
   assign q_push     = req_tvalid && req_tready;

   erp_front u_front (
      .cfg          (cfg),
      .opcode       (req_tuser[0]),
      .total_len    (req_tdata[15:0]),
      .header_words (req_tdata[19:16]),
      .packet_ident (req_tdata[35:20]),
      .icmp_kind    (req_tdata[43:36]),
      .echo_seq     (req_tdata[59:44]),
      .sent_sec     (req_tdata[91:60]),
      .sent_usec    (req_tdata[111:92]),
      .now_sec      (req_tdata[143:112]),
      .now_usec     (req_tdata[163:144]),
      .item         (front_item)
   );

   erp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   erp_back #(
      .MAP_BITS (MAP_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .result    (result)
   );

   // Result packing.
   assign rsp_tuser = result.event_res;
   assign rsp_tdata = {result.trip_total, result.trip_max, result.trip_min, result.dup_total,
                       result.recv_total, result.sent_total, result.trip_us, result.kind_out,
                       result.icmp_bytes, result.seq_out};

endmodule

FILE: hw/rtl/erp_front.sv
// Front part of the echo reply tracker: classifies an incoming item and scales its time stamps.
// Depends on erp_pkg.
`timescale 1ns / 1ps

module erp_front
   import erp_pkg::*;
(
   input  erp_cfg_type  cfg,
   input  logic         opcode,
   input  logic [15:0]  total_len,
   input  logic [3:0]   header_words,
   input  logic [15:0]  packet_ident,
   input  logic [7:0]   icmp_kind,
   input  logic [15:0]  echo_seq,
   input  logic [31:0]  sent_sec,
   input  logic [19:0]  sent_usec,
   input  logic [31:0]  now_sec,
   input  logic [19:0]  now_usec,
   output erp_item_type item
);

   logic [15:0]        hdr_bytes;
   logic [15:0]        net_bytes;
   logic               accepted;
   logic               timed;
   logic signed [32:0] sec_diff;
   logic signed [20:0] usec_diff;
   logic signed [53:0] sec_scaled;

   // Length of the ICMP part, clamped at zero when the header claims more than the packet.
   assign hdr_bytes = {10'd0, header_words, 2'b00};
   assign net_bytes = (total_len >= hdr_bytes) ? (total_len - hdr_bytes) : 16'd0;

   // A received packet counts only when long enough and carrying our identifier.
   assign accepted = ({1'b0, total_len} >= ({1'b0, cfg.payload_size} + ICMP_HDR_BYTES)) &&
                     (packet_ident == cfg.echo_ident);
   assign timed    = (cfg.payload_size >= TIMED_MIN_SIZE);

   // Round-trip parts: the seconds difference is scaled here, the sum is formed in the back.
   assign sec_diff   = $signed({1'b0, now_sec}) - $signed({1'b0, sent_sec});
   assign usec_diff  = $signed({1'b0, now_usec}) - $signed({1'b0, sent_usec});
   assign sec_scaled = sec_diff * USEC_PER_SEC;

   // Classification of the item.
   always_comb begin
      item       = '0;
      item.prod  = sec_scaled;
      item.udiff = usec_diff;
      item.timed = timed;
      if (opcode == OPC_TRANSMIT) begin
         item.op    = OP_TX;
         item.kind  = KIND_REQUEST;
      end else if (!accepted) begin
         item.op    = OP_IGNORE;
      end else if (icmp_kind == KIND_REPLY) begin
         item.op    = OP_REPLY;
         item.seq   = echo_seq;
         item.bytes = net_bytes;
      end else if (icmp_kind == KIND_REQUEST) begin
         item.op    = OP_IGNORE;
      end else begin
         item.op    = OP_OTHER;
         item.bytes = net_bytes;
         item.kind  = icmp_kind;
      end
   end

endmodule

FILE: hw/rtl/erp_queue.sv
// Short queue of classified items between the front and the back of the echo reply tracker.
// Depends on erp_pkg.
`timescale 1ns / 1ps

module erp_queue
   import erp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  erp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output erp_item_type head,
   output logic         empty
);

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   erp_item_type           slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full  = (count_ff == CNT_W'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/erp_back.sv
// Back part of the echo reply tracker: seen map memory, statistics and the result register.
// Depends on erp_pkg.
`timescale 1ns / 1ps

module erp_back
   import erp_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  erp_item_type   head,
   input  logic           empty,
   output logic           pop,
   output logic           clearing,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output erp_result_type result
);

   localparam int IDX_W = $clog2(MAP_BITS);
   localparam int ROWS  = MAP_BITS / ROW_BITS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int BIT_W = $clog2(ROW_BITS);

   erp_back_state_type   state_ff, state_in;

   logic [ROW_BITS-1:0]  map_mem [ROWS];
   logic [ROW_BITS-1:0]  rd_row_ff;
   logic [ROW_W-1:0]     clr_row_ff, clr_row_in;
   logic                 mem_we;
   logic [ROW_W-1:0]     mem_waddr;
   logic [ROW_BITS-1:0]  mem_wdata;
   logic [IDX_W-1:0]     rd_idx;

   // Item held between the map read and the commit.
   erp_op_type           s1_op_ff;
   logic                 s1_timed_ff;
   logic [15:0]          s1_seq_ff;
   logic [15:0]          s1_bytes_ff;
   logic [7:0]           s1_kind_ff;
   logic signed [31:0]   s1_trip_ff, s1_trip_in;
   logic [IDX_W-1:0]     s1_idx_ff;

   logic [31:0]          sent_ff, sent_in;
   logic [31:0]          recv_ff, recv_in;
   logic [31:0]          dup_ff, dup_in;
   logic signed [31:0]   min_ff, min_in;
   logic signed [31:0]   max_ff, max_in;
   logic signed [47:0]   sum_ff, sum_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   erp_result_type       result_ff, result_in;

   logic                 out_free;
   logic                 commit;
   logic                 clr_we;
   logic signed [54:0]   trip_wide;
   logic signed [48:0]   sum_wide;
   logic [ROW_BITS-1:0]  row_mod;
   logic                 row_we;
   logic                 seen;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // Sequencer: clearing pass, then fetch and commit for each item.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            if (!empty) begin
               state_in = BK_COMMIT;
            end
         end
         BK_COMMIT: begin
            if (out_free) begin
               state_in = BK_FETCH;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      pop    = 1'b0;
      commit = 1'b0;
      clr_we = 1'b0;
      unique case (state_ff)
         BK_CLEAR:  clr_we = 1'b1;
         BK_FETCH:  pop    = !empty;
         BK_COMMIT: commit = out_free;
         default:   clr_we = 1'b0;
      endcase
   end

   // Clearing pass row counter.
   assign clr_row_in = clr_we ? clr_row_ff + 1'b1 : clr_row_ff;

   // Map row to read: the send count for a transmit, the reply sequence otherwise.
   assign rd_idx = (head.op == OP_TX) ? sent_ff[IDX_W-1:0] : head.seq[IDX_W-1:0];

   // Round trip of the head item, saturated to 32 bits; zero when timing is off or the item is not a reply.
   assign trip_wide = 55'(head.prod) + 55'(head.udiff);
   always_comb begin
      if (!head.timed || head.op != OP_REPLY) begin
         s1_trip_in = '0;
      end else if (trip_wide > 55'(TRIP_MAX)) begin
         s1_trip_in = TRIP_MAX;
      end else if (trip_wide < 55'(TRIP_MIN)) begin
         s1_trip_in = TRIP_MIN;
      end else begin
         s1_trip_in = trip_wide[31:0];
      end
   end

   // Commit datapath: map update, statistics and the result item.
   assign sum_wide = 49'(sum_ff) + 49'(s1_trip_ff);
   assign seen     = rd_row_ff[s1_idx_ff[BIT_W-1:0]];

   always_comb begin
      sent_in   = sent_ff;
      recv_in   = recv_ff;
      dup_in    = dup_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      row_mod   = rd_row_ff;
      row_we    = 1'b0;
      result_in = '0;
      case (s1_op_ff)
         OP_TX: begin
            row_mod[s1_idx_ff[BIT_W-1:0]] = 1'b0;
            row_we              = 1'b1;
            result_in.event_res = EV_SENT;
            result_in.seq_out   = sent_ff[15:0];
            result_in.kind_out  = KIND_REQUEST;
            if (sent_ff != COUNT_MAX) begin
               sent_in = sent_ff + 32'd1;
            end
         end
         OP_OTHER: begin
            result_in.event_res  = EV_OTHER;
            result_in.icmp_bytes = s1_bytes_ff;
            result_in.kind_out   = s1_kind_ff;
         end
         OP_REPLY: begin
            result_in.seq_out    = s1_seq_ff;
            result_in.icmp_bytes = s1_bytes_ff;
            result_in.trip_us    = s1_trip_ff;
            if (s1_timed_ff) begin
               if (sum_wide[48] != sum_wide[47]) begin
                  sum_in = sum_wide[48] ? SUM_MIN : SUM_MAX;
               end else begin
                  sum_in = sum_wide[47:0];
               end
               if (s1_trip_ff < min_ff) begin
                  min_in = s1_trip_ff;
               end
               if (s1_trip_ff > max_ff) begin
                  max_in = s1_trip_ff;
               end
            end
            if (seen) begin
               result_in.event_res = EV_DUP;
               if (dup_ff != COUNT_MAX) begin
                  dup_in = dup_ff + 32'd1;
               end
            end else begin
               result_in.event_res = EV_NEW;
               row_mod[s1_idx_ff[BIT_W-1:0]] = 1'b1;
               row_we = 1'b1;
               if (recv_ff != COUNT_MAX) begin
                  recv_in = recv_ff + 32'd1;
               end
            end
         end
         default: begin
            result_in.event_res = EV_IGNORED;
         end
      endcase
      result_in.sent_total = sent_in;
      result_in.recv_total = recv_in;
      result_in.dup_total  = dup_in;
      result_in.trip_min   = min_in;
      result_in.trip_max   = max_in;
      result_in.trip_total = sum_in;
   end

   // Memory write port: zero rows during the clearing pass, modified row on commit.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s1_idx_ff[IDX_W-1:BIT_W];
      mem_wdata = row_mod;
      if (clr_we) begin
         mem_we    = 1'b1;
         mem_waddr = clr_row_ff;
         mem_wdata = '0;
      end else if (commit) begin
         mem_we    = row_we;
      end
   end

   // Result register: loaded on commit, released when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Seen map memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
   end

   // The row is read when the item is popped and held until its commit.
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_row_ff <= map_mem[rd_idx[IDX_W-1:BIT_W]];
      end
   end

   // Control and statistics state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
         recv_ff      <= '0;
         dup_ff       <= '0;
         min_ff       <= TRIP_MAX;
         max_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            sent_ff <= sent_in;
            recv_ff <= recv_in;
            dup_ff  <= dup_in;
            min_ff  <= min_in;
            max_ff  <= max_in;
            sum_ff  <= sum_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff    <= head.op;
         s1_timed_ff <= head.timed;
         s1_seq_ff   <= head.seq;
         s1_bytes_ff <= head.bytes;
         s1_kind_ff  <= head.kind;
         s1_trip_ff  <= s1_trip_in;
         s1_idx_ff   <= rd_idx;
      end
      if (commit) begin
         result_ff <= result_in;
      end
   end

endmodule

FILE: tb/tb_echo_reply_tracker.sv
// Self-checking testbench for echo_reply_tracker: a directed table, then random packet traffic
// under four idling schemes, every result item checked against a behavioural tracker model.
// Depends on erp_pkg and the echo_reply_tracker RTL only.
`timescale 1ns / 1ps

module tb_echo_reply_tracker;
   import erp_pkg::*;

   localparam int MAP_BITS = MAP_BITS_DEF;

   // One input item, field by field.
   typedef struct packed {
      logic        opcode;
      logic [15:0] total_len;
      logic [3:0]  header_words;
      logic [15:0] packet_ident;
      logic [7:0]  icmp_kind;
      logic [15:0] echo_seq;
      logic [31:0] sent_sec;
      logic [19:0] sent_usec;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
   } packet_item_type;

   // One row of the directed table: either a register write or an item, with an optional
   // event and sequence typed in by hand.
   typedef struct {
      logic            write_reg;
      logic            reg_idx;
      logic [15:0]     reg_value;
      packet_item_type item;
      logic            pinned;
      erp_event_type   pin_event;
      logic [15:0]     pin_seq;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [279:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Tracker state as the block should hold it.
   logic               seen_bits [MAP_BITS];
   logic [31:0]        sent_count = '0;
   logic [31:0]        recv_count = '0;
   logic [31:0]        dup_count = '0;
   logic signed [31:0] min_trip = TRIP_MAX;
   logic signed [31:0] max_trip = '0;
   logic signed [47:0] sum_trip = '0;
   logic [15:0]        cfg_ident = ECHO_IDENT_RST;
   logic [15:0]        cfg_payload = PAYLOAD_SIZE_RST;

   erp_result_type expected_reports [$];
   int             mismatch_count = 0;
   int             send_gap_pct = 0;
   int             stall_pct = 0;

   echo_reply_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (seen_bits[i]) seen_bits[i] = 1'b0;
   end

   // Works out the report for one accepted item and moves the tracker state on.
   function automatic erp_result_type track_packet(packet_item_type it);
      erp_result_type r;
      longint         trip64;
      longint         sum64;
      int             hbytes;
      int             net;
      int unsigned    slot;
      r = '0;
      r.event_res = EV_IGNORED;
      if (it.opcode == OPC_TRANSMIT) begin
         seen_bits[sent_count % MAP_BITS] = 1'b0;
         r.seq_out = sent_count[15:0];
         r.kind_out = KIND_REQUEST;
         r.event_res = EV_SENT;
         if (sent_count != COUNT_MAX) sent_count = sent_count + 1;
      end else if (int'(it.total_len) >= int'(cfg_payload) + int'(ICMP_HDR_BYTES)
                   && it.packet_ident == cfg_ident) begin
         hbytes = 4 * int'(it.header_words);
         net = (int'(it.total_len) >= hbytes) ? int'(it.total_len) - hbytes : 0;
         if (it.icmp_kind == KIND_REPLY) begin
            r.icmp_bytes = net[15:0];
            r.seq_out = it.echo_seq;
            // Round trip in microseconds, saturated, and folded into the statistics.
            if (cfg_payload >= TIMED_MIN_SIZE) begin
               trip64 = (longint'(it.now_sec) - longint'(it.sent_sec)) * 64'sd1000000
                        + (longint'(it.now_usec) - longint'(it.sent_usec));
               if (trip64 > longint'(TRIP_MAX)) trip64 = longint'(TRIP_MAX);
               if (trip64 < longint'(TRIP_MIN)) trip64 = longint'(TRIP_MIN);
               r.trip_us = trip64[31:0];
               sum64 = longint'(sum_trip) + trip64;
               if (sum64 > longint'(SUM_MAX)) sum64 = longint'(SUM_MAX);
               if (sum64 < longint'(SUM_MIN)) sum64 = longint'(SUM_MIN);
               sum_trip = sum64[47:0];
               if (r.trip_us < min_trip) min_trip = r.trip_us;
               if (r.trip_us > max_trip) max_trip = r.trip_us;
            end
            slot = it.echo_seq % MAP_BITS;
            if (seen_bits[slot]) begin
               if (dup_count != COUNT_MAX) dup_count = dup_count + 1;
               r.event_res = EV_DUP;
            end else begin
               seen_bits[slot] = 1'b1;
               if (recv_count != COUNT_MAX) recv_count = recv_count + 1;
               r.event_res = EV_NEW;
            end
         end else if (it.icmp_kind != KIND_REQUEST) begin
            r.icmp_bytes = net[15:0];
            r.kind_out = it.icmp_kind;
            r.event_res = EV_OTHER;
         end
      end
      r.sent_total = sent_count;
      r.recv_total = recv_count;
      r.dup_total = dup_count;
      r.trip_min = min_trip;
      r.trip_max = max_trip;
      r.trip_total = sum_trip;
      return r;
   endfunction

   // Random item: replies to recent requests as the largest share, mostly well-formed, plus transmits and noise.
   function automatic packet_item_type random_packet();
      packet_item_type it;
      int              pick;
      int              len;
      it.opcode = OPC_RECEIVE;
      it.total_len = 16'($urandom);
      it.header_words = 4'($urandom);
      it.packet_ident = 16'($urandom);
      it.icmp_kind = 8'($urandom);
      it.echo_seq = 16'($urandom);
      it.sent_sec = $urandom;
      it.sent_usec = 20'($urandom_range(0, 999999));
      it.now_sec = $urandom;
      it.now_usec = 20'($urandom_range(0, 999999));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         it.opcode = OPC_TRANSMIT;
      end else if (pick < 90) begin
         len = int'(cfg_payload) + 8 + $urandom_range(0, 64);
         if ($urandom_range(0, 9) == 0) len = int'(cfg_payload) + 7;
         if (len > 65535) len = 65535;
         it.total_len = len[15:0];
         it.header_words = 4'($urandom_range(5, 15));
         it.packet_ident = cfg_ident;
         it.now_sec = it.sent_sec + $urandom_range(0, 2);
         if (pick < 78) begin
            it.icmp_kind = KIND_REPLY;
            it.echo_seq = sent_count[15:0] - 16'($urandom_range(1, 24));
         end else if (pick < 82) begin
            it.icmp_kind = KIND_REQUEST;
         end
      end else if ($urandom_range(0, 1) == 1) begin
         it.packet_ident = cfg_ident;
      end
      return it;
   endfunction

   function automatic stim_row_type cfg_row(logic idx, logic [15:0] value);
      stim_row_type row;
      row = '{pin_event: EV_IGNORED, default: '0};
      row.write_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_value = value;
      return row;
   endfunction

   function automatic stim_row_type tx_row(logic [15:0] seq);
      stim_row_type row;
      row = '{pin_event: EV_IGNORED, default: '0};
      row.item.opcode = OPC_TRANSMIT;
      row.pinned = 1'b1;
      row.pin_event = EV_SENT;
      row.pin_seq = seq;
      return row;
   endfunction

   function automatic stim_row_type rx_row(logic [15:0] len, logic [3:0] hwords,
                                           logic [15:0] ident, logic [7:0] kind,
                                           logic [15:0] seq, logic [31:0] ssec,
                                           logic [19:0] susec, logic [31:0] nsec,
                                           logic [19:0] nusec, logic pinned,
                                           erp_event_type ev, logic [15:0] pseq);
      stim_row_type row;
      row = '{pin_event: EV_IGNORED, default: '0};
      row.item = '{OPC_RECEIVE, len, hwords, ident, kind, seq, ssec, susec, nsec, nusec};
      row.pinned = pinned;
      row.pin_event = ev;
      row.pin_seq = pseq;
      return row;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic compare_report(erp_result_type got, erp_result_type want);
      if (got.event_res !== want.event_res)
         report_mismatch("event_res", got.event_res, want.event_res);
      if (got.seq_out !== want.seq_out) report_mismatch("seq_out", got.seq_out, want.seq_out);
      if (got.icmp_bytes !== want.icmp_bytes)
         report_mismatch("icmp_bytes", got.icmp_bytes, want.icmp_bytes);
      if (got.kind_out !== want.kind_out)
         report_mismatch("kind_out", got.kind_out, want.kind_out);
      if (got.trip_us !== want.trip_us) report_mismatch("trip_us", got.trip_us, want.trip_us);
      if (got.sent_total !== want.sent_total)
         report_mismatch("sent_total", got.sent_total, want.sent_total);
      if (got.recv_total !== want.recv_total)
         report_mismatch("recv_total", got.recv_total, want.recv_total);
      if (got.dup_total !== want.dup_total)
         report_mismatch("dup_total", got.dup_total, want.dup_total);
      if (got.trip_min !== want.trip_min)
         report_mismatch("trip_min", got.trip_min, want.trip_min);
      if (got.trip_max !== want.trip_max)
         report_mismatch("trip_max", got.trip_max, want.trip_max);
      if (got.trip_total !== want.trip_total)
         report_mismatch("trip_total", got.trip_total, want.trip_total);
   endtask

   // Offers one item after an optional gap and records its expected report once accepted.
   task automatic send_item(packet_item_type it, int gap, logic pinned,
                            erp_event_type pin_event, logic [15:0] pin_seq);
      erp_result_type want;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.opcode;
      req_tdata <= {4'b0, it.now_usec, it.now_sec, it.sent_usec, it.sent_sec, it.echo_seq,
                    it.icmp_kind, it.packet_ident, it.header_words, it.total_len};
      do @(posedge clock); while (!req_tready);
      want = track_packet(it);
      if (pinned) begin
         want.event_res = pin_event;
         want.seq_out = pin_seq;
      end
      expected_reports.push_back(want);
   endtask

   // Register write, only once every outstanding item has been reported.
   task automatic write_register(logic idx, logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_ECHO_IDENT) cfg_ident = value;
      else cfg_payload = value;
   endtask

   // Result side: random back-pressure and the check of every accepted result item.
   always @(posedge clock) begin
      erp_result_type got;
      erp_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.event_res = erp_event_type'(rsp_tuser);
            got.seq_out = rsp_tdata[15:0];
            got.icmp_bytes = rsp_tdata[31:16];
            got.kind_out = rsp_tdata[39:32];
            got.trip_us = rsp_tdata[71:40];
            got.sent_total = rsp_tdata[103:72];
            got.recv_total = rsp_tdata[135:104];
            got.dup_total = rsp_tdata[167:136];
            got.trip_min = rsp_tdata[199:168];
            got.trip_max = rsp_tdata[231:200];
            got.trip_total = rsp_tdata[279:232];
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected result item", got.seq_out, '0);
            end else begin
               want = expected_reports.pop_front();
               compare_report(got, want);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Main sequence: reset, directed table, random phases, then drain and verdict.
   initial begin
      stim_row_type    rows [$];
      packet_item_type it;
      int              gap;

      // Reset state, echo bookkeeping and timing.
      rows.push_back(tx_row(16'd0));
      rows.push_back(tx_row(16'd1));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 0, 100, 0, 100, 500, 1, EV_NEW, 0));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 0, 100, 0, 100, 900, 1, EV_DUP, 0));
      // Length one short of the minimum, then exactly the minimum.
      rows.push_back(rx_row(63, 5, 0, KIND_REPLY, 1, 100, 0, 100, 1, 1, EV_IGNORED, 0));
      rows.push_back(rx_row(64, 5, 0, KIND_REPLY, 1, 200, 999999, 201, 0, 1, EV_NEW, 1));
      // Foreign identifier, an echo request and other ICMP types.
      rows.push_back(rx_row(84, 5, 1, KIND_REPLY, 9, 0, 0, 0, 0, 1, EV_IGNORED, 0));
      rows.push_back(rx_row(84, 5, 0, KIND_REQUEST, 9, 0, 0, 0, 0, 1, EV_IGNORED, 0));
      rows.push_back(rx_row(84, 5, 0, 8'd3, 9, 0, 0, 0, 0, 1, EV_OTHER, 0));
      rows.push_back(rx_row(65535, 15, 0, 8'd255, 65535, 0, 0, 0, 0, 1, EV_OTHER, 0));
      // Negative trip, and trips that saturate at both ends.
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 2, 200, 0, 100, 0, 0, EV_IGNORED, 0));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 3, 0, 0, 32'hFFFF_FFFF, 999999,
                            0, EV_IGNORED, 0));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 4, 32'hFFFF_FFFF, 999999, 0, 0,
                            0, EV_IGNORED, 0));
      // Sequences that share one map slot.
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 65535, 7, 0, 7, 10, 1, EV_NEW, 65535));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 16383, 7, 0, 7, 10, 1, EV_DUP, 16383));
      // A transmit clears the slot of its sequence.
      rows.push_back(tx_row(16'd2));
      rows.push_back(rx_row(84, 5, 0, KIND_REPLY, 2, 7, 0, 7, 10, 1, EV_NEW, 2));
      // Empty payload: header longer than the packet.
      rows.push_back(cfg_row(REG_PAYLOAD_SIZE, 16'd0));
      rows.push_back(rx_row(8, 15, 0, KIND_REPLY, 5, 1, 0, 2, 0, 1, EV_NEW, 5));
      rows.push_back(rx_row(8, 15, 0, 8'd3, 5, 0, 0, 0, 0, 1, EV_OTHER, 0));
      // Payload too small to carry a timestamp: timing off.
      rows.push_back(cfg_row(REG_PAYLOAD_SIZE, 16'd7));
      rows.push_back(rx_row(15, 5, 0, KIND_REPLY, 6, 0, 0, 50, 0, 1, EV_NEW, 6));
      // Largest identifier and payload.
      rows.push_back(cfg_row(REG_ECHO_IDENT, 16'hFFFF));
      rows.push_back(cfg_row(REG_PAYLOAD_SIZE, 16'd65507));
      rows.push_back(rx_row(65515, 5, 16'hFFFF, KIND_REPLY, 7, 3, 0, 3, 77, 1, EV_NEW, 7));
      rows.push_back(rx_row(65514, 5, 16'hFFFF, KIND_REPLY, 8, 3, 0, 3, 77,
                            1, EV_IGNORED, 0));
      rows.push_back(rx_row(65535, 5, 0, KIND_REPLY, 8, 3, 0, 3, 77, 1, EV_IGNORED, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].write_reg) write_register(rows[i].reg_idx, rows[i].reg_value);
         else send_item(rows[i].item, 0, rows[i].pinned, rows[i].pin_event, rows[i].pin_seq);
      end

      // Random phases: each with its own register setting and one of the four idling schemes.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(REG_ECHO_IDENT, 16'($urandom));
               write_register(REG_PAYLOAD_SIZE, 16'd56);
            end
            1: begin
               write_register(REG_ECHO_IDENT, 16'hFFFF);
               write_register(REG_PAYLOAD_SIZE, 16'd65507);
            end
            2: begin
               write_register(REG_ECHO_IDENT, 16'h0000);
               write_register(REG_PAYLOAD_SIZE, 16'd0);
            end
            3: begin
               write_register(REG_ECHO_IDENT, 16'($urandom));
               write_register(REG_PAYLOAD_SIZE, 16'd7);
            end
            4: begin
               write_register(REG_ECHO_IDENT, 16'($urandom));
               write_register(REG_PAYLOAD_SIZE, 16'd8);
            end
            default: begin
               write_register(REG_ECHO_IDENT, 16'($urandom));
               write_register(REG_PAYLOAD_SIZE, 16'($urandom_range(0, 1500)));
            end
         endcase
         case (phase % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 53; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 53; end
            default: begin send_gap_pct = 21; stall_pct = 21; end
         endcase
         repeat (200) begin
            it = random_packet();
            gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
            send_item(it, gap, 1'b0, EV_IGNORED, 16'h0000);
         end
      end

      // Drain the outstanding reports, then give the pipeline time to show any stray item.
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("[echo_reply_tracker] OK");
      else
         $display("[echo_reply_tracker] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20000000;
      $display("[echo_reply_tracker] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/erp_pkg.sv
hw/rtl/erp_front.sv
hw/rtl/erp_queue.sv
hw/rtl/erp_back.sv
hw/rtl/echo_reply_tracker.sv
tb/tb_echo_reply_tracker.sv
